// ===== sv/dcm_pkg.sv =====
// Shared types, constants and arithmetic helpers for the discrete DC motor model.
// Used by every module of the block; depends on nothing else.
package dcm_pkg;

    localparam int Q_W           = 32;
    localparam int LIMIT_W       = 31;
    localparam int DIGIT_W       = 4;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int STEP_W        = 3;

    localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = LIMIT_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODEL_MODE  = 3'd0,
        CFG_DRIVE_LIMIT = 3'd1,
        CFG_COEF_A0     = 3'd2,
        CFG_COEF_A1     = 3'd3,
        CFG_COEF_A2     = 3'd4,
        CFG_COEF_B0     = 3'd5,
        CFG_COEF_B1     = 3'd6,
        CFG_COEF_B2     = 3'd7
    } cfg_idx_t;

    typedef enum logic [STEP_W-1:0] {
        STEP_A2 = 3'd0,
        STEP_A1 = 3'd1,
        STEP_A0 = 3'd2,
        STEP_B2 = 3'd3,
        STEP_B1 = 3'd4,
        STEP_B0 = 3'd5
    } step_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MUL  = 2'd1,
        ST_HOLD = 2'd2
    } seq_state_t;

    typedef struct packed {
        logic                    model_mode;
        logic [LIMIT_W-1:0]      drive_limit;
        logic signed [Q_W-1:0]   coef_a0;
        logic signed [Q_W-1:0]   coef_a1;
        logic signed [Q_W-1:0]   coef_a2;
        logic signed [Q_W-1:0]   coef_b0;
        logic signed [Q_W-1:0]   coef_b1;
        logic signed [Q_W-1:0]   coef_b2;
    } cfg_t;

    // Arithmetic right shift of a full product, then saturation to 32 bits.
    function automatic logic signed [Q_W-1:0] qscale_sat(
        input logic signed [2*Q_W-1:0] p,
        input int                      frac
    );
        logic signed [2*Q_W-1:0] s;
        begin
            s = p >>> frac;
            if (s[2*Q_W-1:Q_W-1] == '0 || s[2*Q_W-1:Q_W-1] == '1)
                qscale_sat = s[Q_W-1:0];
            else if (s[2*Q_W-1])
                qscale_sat = {1'b1, {(Q_W-1){1'b0}}};
            else
                qscale_sat = {1'b0, {(Q_W-1){1'b1}}};
        end
    endfunction

    // Saturation of a widened sum to 32 bits.
    function automatic logic signed [Q_W-1:0] sum_sat(input logic signed [Q_W+1:0] v);
        begin
            if (v[Q_W+1:Q_W-1] == '0 || v[Q_W+1:Q_W-1] == '1)
                sum_sat = v[Q_W-1:0];
            else if (v[Q_W+1])
                sum_sat = {1'b1, {(Q_W-1){1'b0}}};
            else
                sum_sat = {1'b0, {(Q_W-1){1'b1}}};
        end
    endfunction

    // Symmetric clamp to plus or minus the drive limit.
    function automatic logic signed [Q_W-1:0] clamp_lim(
        input logic signed [Q_W-1:0] v,
        input logic [LIMIT_W-1:0]    lim
    );
        logic signed [Q_W:0] vx;
        logic signed [Q_W:0] lx;
        logic signed [Q_W:0] nx;
        begin
            vx = {v[Q_W-1], v};
            lx = {2'b00, lim};
            nx = -lx;
            if (vx >= lx)
                clamp_lim = lx[Q_W-1:0];
            else if (vx <= nx)
                clamp_lim = nx[Q_W-1:0];
            else
                clamp_lim = v;
        end
    endfunction

endpackage

// ===== sv/dcm_serial_mul.sv =====
// Digit-serial signed 32 x 32 multiplier giving the full 64-bit product.
// The multiplier operand is consumed one 4-bit digit per cycle; uses dcm_pkg.
module dcm_serial_mul (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [dcm_pkg::Q_W-1:0]   op_a,
    input  logic signed [dcm_pkg::Q_W-1:0]   op_b,
    output logic                             done,
    output logic signed [2*dcm_pkg::Q_W-1:0] product
);
    import dcm_pkg::*;

    localparam int STEPS = Q_W / DIGIT_W;
    localparam int CNT_W = $clog2(STEPS);
    localparam int TW    = Q_W + DIGIT_W + 1;
    localparam int HW    = Q_W + DIGIT_W + 2;

    logic signed [Q_W-1:0]  a_reg, a_next;
    logic [Q_W-1:0]         b_reg, b_next;
    logic signed [HW-1:0]   hi_reg, hi_next;
    logic [Q_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    logic                   last_digit;
    logic signed [DIGIT_W:0] digit_s;
    logic signed [TW-1:0]   term;
    logic signed [HW-1:0]   sum;

    always_comb
    begin
        last_digit = (cnt_reg == CNT_W'(STEPS - 1));
        if (last_digit)
            digit_s = {b_reg[DIGIT_W-1], b_reg[DIGIT_W-1:0]};
        else
            digit_s = {1'b0, b_reg[DIGIT_W-1:0]};
        term = TW'(a_reg) * TW'(digit_s);
        sum  = hi_reg + {{(HW-TW){term[TW-1]}}, term};

        a_next    = a_reg;
        b_next    = b_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = op_a;
            b_next    = op_b;
            hi_next   = '0;
            lo_next   = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            hi_next  = sum >>> DIGIT_W;
            lo_next  = {sum[DIGIT_W-1:0], lo_reg[Q_W-1:DIGIT_W]};
            b_next   = b_reg >> DIGIT_W;
            cnt_next = cnt_reg + CNT_W'(1);
            if (last_digit)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg[Q_W-1:0], lo_reg};

endmodule

// ===== sv/dcm_seq.sv =====
// Sequencer for the six products of one tick, with accumulator and motor state.
// Uses dcm_pkg and one dcm_serial_mul instance.
module dcm_seq #(
    parameter int FRAC_BITS = dcm_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dcm_pkg::cfg_t                  cfg,
    input  logic                           clear_state,
    input  logic                           start,
    input  logic signed [dcm_pkg::Q_W-1:0] cmd,
    input  logic signed [dcm_pkg::Q_W-1:0] load,
    output logic                           idle,
    output logic                           res_valid,
    input  logic                           res_take,
    output logic signed [dcm_pkg::Q_W-1:0] res
);
    import dcm_pkg::*;

    seq_state_t            state_reg, state_next;
    step_t                 step_reg, step_next;
    logic                  mul_start_reg, mul_start_next;
    logic signed [Q_W-1:0] cmd_reg, cmd_next;
    logic signed [Q_W-1:0] load_reg, load_next;
    logic signed [Q_W-1:0] acc_reg, acc_next;
    logic signed [Q_W-1:0] cur_reg, cur_next;
    logic signed [Q_W-1:0] res_reg, res_next;
    logic signed [Q_W-1:0] last_cur_reg, last_cur_next;
    logic signed [Q_W-1:0] last_spd_reg, last_spd_next;

    logic                    fwd;
    logic signed [Q_W-1:0]   mul_a;
    logic signed [Q_W-1:0]   mul_b;
    logic                    mul_done;
    logic signed [2*Q_W-1:0] mul_p;
    logic signed [Q_W-1:0]   q;
    logic                    add_q;
    logic signed [Q_W+1:0]   sum_w;
    logic signed [Q_W-1:0]   sum_s;

    dcm_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    assign fwd = cfg.model_mode;

    always_comb
    begin
        unique case (step_reg)
            STEP_A2:
            begin
                mul_a = cfg.coef_a2;
                mul_b = fwd ? last_cur_reg : load_reg;
            end
            STEP_A1:
            begin
                mul_a = cfg.coef_a1;
                mul_b = fwd ? last_spd_reg : cmd_reg;
            end
            STEP_A0:
            begin
                mul_a = cfg.coef_a0;
                mul_b = fwd ? clamp_lim(cmd_reg, cfg.drive_limit) : last_spd_reg;
            end
            STEP_B2:
            begin
                mul_a = cfg.coef_b2;
                mul_b = fwd ? last_spd_reg : cmd_reg;
            end
            STEP_B1:
            begin
                mul_a = cfg.coef_b1;
                mul_b = cur_reg;
            end
            STEP_B0:
            begin
                mul_a = cfg.coef_b0;
                mul_b = fwd ? load_reg : last_cur_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        q     = qscale_sat(mul_p, FRAC_BITS);
        add_q = (step_reg == STEP_A1 && !fwd) || (step_reg == STEP_A0 && fwd)
                || (step_reg == STEP_B1);
        if (add_q)
            sum_w = {{2{acc_reg[Q_W-1]}}, acc_reg} + {{2{q[Q_W-1]}}, q};
        else
            sum_w = {{2{acc_reg[Q_W-1]}}, acc_reg} - {{2{q[Q_W-1]}}, q};
        sum_s = sum_sat(sum_w);
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        mul_start_next = 1'b0;
        cmd_next       = cmd_reg;
        load_next      = load_reg;
        acc_next       = acc_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        last_cur_next  = last_cur_reg;
        last_spd_next  = last_spd_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next       = cmd;
                    load_next      = load;
                    step_next      = STEP_A2;
                    mul_start_next = 1'b1;
                    state_next     = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    if (step_reg == STEP_A2 || step_reg == STEP_B2)
                        acc_next = q;
                    else
                        acc_next = sum_s;
                    if (step_reg == STEP_A0)
                        cur_next = sum_s;
                    if (step_reg == STEP_B0)
                    begin
                        last_cur_next = cur_reg;
                        last_spd_next = fwd ? sum_s : cmd_reg;
                        res_next      = fwd ? sum_s : clamp_lim(sum_s, cfg.drive_limit);
                        state_next    = ST_HOLD;
                    end
                    else
                    begin
                        step_next      = step_t'(step_reg + STEP_W'(1));
                        mul_start_next = 1'b1;
                    end
                end
            end
            ST_HOLD:
            begin
                if (res_take)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (clear_state)
        begin
            last_cur_next = '0;
            last_spd_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_A2;
            mul_start_reg <= 1'b0;
            last_cur_reg  <= '0;
            last_spd_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            mul_start_reg <= mul_start_next;
            last_cur_reg  <= last_cur_next;
            last_spd_reg  <= last_spd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        load_reg <= load_next;
        acc_reg  <= acc_next;
        cur_reg  <= cur_next;
        res_reg  <= res_next;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_HOLD);
    assign res       = res_reg;

endmodule

// ===== sv/dc_motor_discrete_model.sv =====
// Top level of the discrete DC motor model: configuration registers, stream ports and
// output register. Depends on dcm_pkg and dcm_seq.
//
// Each beat on the slave stream carries one control tick: the command value and the load
// torque. The block answers every beat with exactly one beat on the master stream,
// the clamped voltage in inverse mode or the modelled speed in forward mode.
// One tick costs six products on a shared multiplier that takes the multiplier operand
// four bits a cycle. A new beat is taken only once the sequencer is idle again, so each
// tick is finished before the next beat is accepted. The output register holds a finished
// result while the next tick is worked on; if the receiver stalls for longer, the
// sequencer holds its result and s_axis_tready stays low until the output register frees.
// Reset loads the register defaults (inverse mode, limit of 1.0, zero coefficients) and
// clears the stored current and speed; any configuration write also clears that state.
// Write configuration only while idle.
module dc_motor_discrete_model #(
    parameter int FRAC_BITS = dcm_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [31:0] command_value, [63:32] load_torque
    input  logic [2*dcm_pkg::Q_W-1:0]        s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] model_result
    output logic [dcm_pkg::Q_W-1:0]          m_axis_tdata,
    input  logic                             cfg_wr_en,
    input  logic [dcm_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [dcm_pkg::Q_W-1:0]          cfg_data
);
    import dcm_pkg::*;

    cfg_t                  cfg_reg, cfg_next;
    logic                  out_valid_reg, out_valid_next;
    logic signed [Q_W-1:0] out_data_reg, out_data_next;

    logic                  seq_idle;
    logic                  seq_valid;
    logic                  seq_take;
    logic signed [Q_W-1:0] seq_res;
    logic                  in_beat;

    assign s_axis_tready = seq_idle;
    assign in_beat       = s_axis_tvalid && seq_idle;
    assign seq_take      = seq_valid && (!out_valid_reg || m_axis_tready);

    dcm_seq #(
        .FRAC_BITS (FRAC_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .clear_state (cfg_wr_en),
        .start       (in_beat),
        .cmd         (s_axis_tdata[Q_W-1:0]),
        .load        (s_axis_tdata[2*Q_W-1:Q_W]),
        .idle        (seq_idle),
        .res_valid   (seq_valid),
        .res_take    (seq_take),
        .res         (seq_res)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_MODEL_MODE:  cfg_next.model_mode  = cfg_data[0];
                CFG_DRIVE_LIMIT: cfg_next.drive_limit = cfg_data[LIMIT_W-1:0];
                CFG_COEF_A0:     cfg_next.coef_a0     = cfg_data;
                CFG_COEF_A1:     cfg_next.coef_a1     = cfg_data;
                CFG_COEF_A2:     cfg_next.coef_a2     = cfg_data;
                CFG_COEF_B0:     cfg_next.coef_b0     = cfg_data;
                CFG_COEF_B1:     cfg_next.coef_b1     = cfg_data;
                CFG_COEF_B2:     cfg_next.coef_b2     = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_axis_tready)
            out_valid_next = 1'b0;
        if (seq_take)
        begin
            out_valid_next = 1'b1;
            out_data_next  = seq_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.model_mode  <= 1'b0;
            cfg_reg.drive_limit <= DRIVE_LIMIT_RST;
            cfg_reg.coef_a0     <= '0;
            cfg_reg.coef_a1     <= '0;
            cfg_reg.coef_a2     <= '0;
            cfg_reg.coef_b0     <= '0;
            cfg_reg.coef_b1     <= '0;
            cfg_reg.coef_b2     <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== bench/tb_dc_motor_discrete_model.sv =====
// Testbench for dc_motor_discrete_model: a directed table, then randomised configuration
// phases, with every output beat checked against the table's value or a fixed-point predictor.
// Depends on dcm_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_dc_motor_discrete_model;
    import dcm_pkg::*;

    localparam int  FRAC       = FRAC_BITS_DEF;
    localparam logic MODE_INVERSE = 1'b0;
    localparam logic MODE_FORWARD = 1'b1;
    localparam bit  ROW_ITEM   = 1'b0;
    localparam bit  ROW_WRITE  = 1'b1;
    localparam int  N_PHASES   = 13;
    localparam int  PHASE_BEATS = 125;
    localparam longint Q_HI    = 64'sd2147483647;
    localparam longint Q_LO    = -64'sd2147483648;

    typedef struct packed {
        bit          is_write;
        cfg_idx_t    reg_idx;
        logic [31:0] wdata;
        logic [31:0] cmd;
        logic [31:0] load;
        bit          typed;
        logic [31:0] result;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [31:0] command_value, [63:32] load_torque
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [31:0] model_result
    logic [31:0] m_axis_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [31:0] cfg_data = '0;

    cfg_t        shadow_cfg;
    longint      est_current;
    longint      est_speed;
    logic [31:0] expected_results [$];
    stim_row_t   directed_rows [$];
    int          err_count = 0;
    int          burst_left = 0;
    int          ready_run = 0;
    int          stall_run = 0;

    dc_motor_discrete_model i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint fx_sat(input longint v);
        if (v > Q_HI)
            return Q_HI;
        if (v < Q_LO)
            return Q_LO;
        return v;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        return fx_sat(p >>> FRAC);
    endfunction

    function automatic longint clamp_drive(input longint v);
        longint lim;
        lim = longint'(shadow_cfg.drive_limit);
        if (v >= lim)
            return lim;
        if (v <= -lim)
            return -lim;
        return v;
    endfunction

    // Advances the estimated motor state by one tick and returns the expected output.
    function automatic logic [31:0] motor_tick(input logic [31:0] cmd, input logic [31:0] load);
        longint c, ld, v, cur, res;
        longint a0, a1, a2, b0, b1, b2;
        c  = longint'($signed(cmd));
        ld = longint'($signed(load));
        a0 = longint'($signed(shadow_cfg.coef_a0));
        a1 = longint'($signed(shadow_cfg.coef_a1));
        a2 = longint'($signed(shadow_cfg.coef_a2));
        b0 = longint'($signed(shadow_cfg.coef_b0));
        b1 = longint'($signed(shadow_cfg.coef_b1));
        b2 = longint'($signed(shadow_cfg.coef_b2));
        if (shadow_cfg.model_mode == MODE_INVERSE)
        begin
            cur = fx_sat(fx_mul(a2, ld) + fx_mul(a1, c));
            cur = fx_sat(cur - fx_mul(a0, est_speed));
            res = fx_sat(fx_mul(b2, c) + fx_mul(b1, cur));
            res = fx_sat(res - fx_mul(b0, est_current));
            est_current = cur;
            est_speed = c;
            res = clamp_drive(res);
        end
        else
        begin
            v   = clamp_drive(c);
            cur = fx_sat(fx_mul(a2, est_current) - fx_mul(a1, est_speed));
            cur = fx_sat(cur + fx_mul(a0, v));
            res = fx_sat(fx_mul(b2, est_speed) + fx_mul(b1, cur));
            res = fx_sat(res - fx_mul(b0, ld));
            est_current = cur;
            est_speed = res;
        end
        return res[31:0];
    endfunction

    function automatic logic [31:0] random_q(input int span);
        int kind;
        kind = $urandom_range(0, 7);
        case (kind)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3, 4, 5: return 32'(longint'($urandom_range(0, 2 * span)) - span);
            default: return $urandom();
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
        err_count++;
    endtask

    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_MODEL_MODE:  shadow_cfg.model_mode  = data[0];
            CFG_DRIVE_LIMIT: shadow_cfg.drive_limit = data[LIMIT_W-1:0];
            CFG_COEF_A0:     shadow_cfg.coef_a0     = data;
            CFG_COEF_A1:     shadow_cfg.coef_a1     = data;
            CFG_COEF_A2:     shadow_cfg.coef_a2     = data;
            CFG_COEF_B0:     shadow_cfg.coef_b0     = data;
            CFG_COEF_B1:     shadow_cfg.coef_b1     = data;
            CFG_COEF_B2:     shadow_cfg.coef_b2     = data;
            default: ;
        endcase
        est_current = 0;
        est_speed = 0;
        @(posedge clk);
    endtask

    task automatic send_tick(input logic [31:0] cmd, input logic [31:0] load,
                             input bit typed, input logic [31:0] want);
        int gap;
        logic [31:0] predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {load, cmd};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = motor_tick(cmd, load);
        expected_results.push_back(typed ? want : predicted);
        burst_left--;
    endtask

    // Output side: checks each accepted beat, then drives its own stall pattern.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("model_result with nothing pending", 32'h0, m_axis_tdata);
                else if (m_axis_tdata !== expected_results[0])
                    report_mismatch("model_result", expected_results.pop_front(), m_axis_tdata);
                else
                    void'(expected_results.pop_front());
            end
            if (ready_run > 0)
            begin
                m_axis_tready <= 1'b1;
                ready_run--;
            end
            else if (stall_run > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_run--;
            end
            else
            begin
                m_axis_tready <= $urandom_range(0, 1);
                ready_run = $urandom_range(1, 40);
                stall_run = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        logic [31:0] wdata;
        shadow_cfg = '0;
        shadow_cfg.model_mode = MODE_INVERSE;
        shadow_cfg.drive_limit = DRIVE_LIMIT_RST;
        est_current = 0;
        est_speed = 0;
        directed_rows = '{
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'h7FFFFFFF, 32'h80000000, 1'b1, 32'h0},
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'h80000000, 32'h7FFFFFFF, 1'b1, 32'h0},
            '{ROW_WRITE, CFG_COEF_B2,     32'h00010000, 32'h0, 32'h0, 1'b0, 32'h0},
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'h7FFFFFFF, 32'h0, 1'b1, 32'h00010000},
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'h80000000, 32'h0, 1'b1, 32'hFFFF0000},
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'h00010000, 32'h0, 1'b1, 32'h00010000},
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'hFFFF0000, 32'h0, 1'b1, 32'hFFFF0000},
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'h00000064, 32'h0, 1'b1, 32'h00000064},
            '{ROW_WRITE, CFG_DRIVE_LIMIT, 32'h00000000, 32'h0, 32'h0, 1'b0, 32'h0},
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'h00003039, 32'hFFFFFFFF, 1'b1, 32'h0},
            '{ROW_WRITE, CFG_DRIVE_LIMIT, 32'h7FFFFFFF, 32'h0, 32'h0, 1'b0, 32'h0},
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'h80000000, 32'h0, 1'b1, 32'h80000001},
            '{ROW_WRITE, CFG_COEF_B2,     32'h7FFFFFFF, 32'h0, 32'h0, 1'b0, 32'h0},
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'h7FFFFFFF, 32'h0, 1'b1, 32'h7FFFFFFF},
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'h80000000, 32'h0, 1'b1, 32'h80000001},
            '{ROW_WRITE, CFG_DRIVE_LIMIT, 32'h80010000, 32'h0, 32'h0, 1'b0, 32'h0},
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'h00020000, 32'h0, 1'b1, 32'h00010000},
            '{ROW_WRITE, CFG_COEF_A0,     32'hFFFF8000, 32'h0, 32'h0, 1'b0, 32'h0},
            '{ROW_WRITE, CFG_COEF_A1,     32'h00018000, 32'h0, 32'h0, 1'b0, 32'h0},
            '{ROW_WRITE, CFG_COEF_A2,     32'h00004000, 32'h0, 32'h0, 1'b0, 32'h0},
            '{ROW_WRITE, CFG_COEF_B0,     32'h00020000, 32'h0, 32'h0, 1'b0, 32'h0},
            '{ROW_WRITE, CFG_COEF_B1,     32'hFFFF0000, 32'h0, 32'h0, 1'b0, 32'h0},
            '{ROW_WRITE, CFG_COEF_B2,     32'h0000C000, 32'h0, 32'h0, 1'b0, 32'h0},
            '{ROW_WRITE, CFG_DRIVE_LIMIT, 32'h00080000, 32'h0, 32'h0, 1'b0, 32'h0},
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'h00010000, 32'h00020000, 1'b0, 32'h0},
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'h00030000, 32'hFFFE0000, 1'b0, 32'h0},
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'hFFFC0000, 32'h7FFFFFFF, 1'b0, 32'h0},
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'h80000000, 32'h80000000, 1'b0, 32'h0},
            '{ROW_WRITE, CFG_MODEL_MODE,  32'hFFFFFFFE, 32'h0, 32'h0, 1'b0, 32'h0},
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'h00050000, 32'h00001000, 1'b0, 32'h0},
            '{ROW_WRITE, CFG_MODEL_MODE,  32'(MODE_FORWARD), 32'h0, 32'h0, 1'b0, 32'h0},
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'h00040000, 32'h00010000, 1'b0, 32'h0},
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'h7FFFFFFF, 32'h00000000, 1'b0, 32'h0},
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'h80000000, 32'h80000000, 1'b0, 32'h0},
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'h00080000, 32'h7FFFFFFF, 1'b0, 32'h0},
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'hFFF80000, 32'h00000000, 1'b0, 32'h0},
            '{ROW_WRITE, CFG_COEF_B0,     32'h80000000, 32'h0, 32'h0, 1'b0, 32'h0},
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'h00001000, 32'h7FFFFFFF, 1'b0, 32'h0},
            '{ROW_ITEM,  CFG_MODEL_MODE,  32'h0, 32'h00001000, 32'h80000000, 1'b0, 32'h0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].is_write == ROW_WRITE)
            begin
                settle_idle();
                cfg_write(directed_rows[r].reg_idx, directed_rows[r].wdata);
            end
            else
                send_tick(directed_rows[r].cmd, directed_rows[r].load,
                          directed_rows[r].typed, directed_rows[r].result);
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            settle_idle();
            for (int k = 0; k < 8; k++)
            begin
                case (cfg_idx_t'(k))
                    CFG_MODEL_MODE:
                        wdata = $urandom();
                    CFG_DRIVE_LIMIT:
                    begin
                        case ($urandom_range(0, 5))
                            0: wdata = 32'h0;
                            1: wdata = 32'h7FFF_FFFF;
                            5: wdata = $urandom();
                            default: wdata = $urandom_range(0, 32'h0010_0000);
                        endcase
                        wdata[31] = $urandom_range(0, 1);
                    end
                    default:
                        wdata = random_q(131072);
                endcase
                cfg_write(cfg_idx_t'(k), wdata);
            end
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                if ($urandom_range(0, 99) == 0)
                    settle_idle();
                send_tick(random_q(1048576), random_q(1048576), 1'b0, 32'h0);
            end
        end

        settle_idle();
        repeat (80) @(posedge clk);
        if (err_count == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== dc_motor_discrete_model.f =====
sv/dcm_pkg.sv
sv/dcm_serial_mul.sv
sv/dcm_seq.sv
sv/dc_motor_discrete_model.sv
bench/tb_dc_motor_discrete_model.sv
